// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/dpc_pkg.sv
// Package for the point clustering unit: widths, word types, FSM and op codes.
// No dependencies.
`default_nettype none
package dpc_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int COORD_BITS = 16;
	localparam int PT_W       = 2 * COORD_BITS;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int SQ_W       = 2 * DIFF_W - 1;   // square magnitude bits
	localparam int SUM_W      = COORD_BITS + IDX_W;
	localparam int STEP_W     = $clog2(SUM_W);
	localparam int EPS_W      = 33;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EPS_SQUARED  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CLUSTERS = 2'd2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x_coord;
		logic signed [COORD_BITS-1:0] y_coord;
		logic                         last_point;
	} point_t;

	typedef struct packed {
		logic [IDX_W-1:0]             point_index;
		logic [IDX_W-1:0]             cluster_label;
		logic                         is_noise;
		logic signed [COORD_BITS-1:0] centroid_x;
		logic signed [COORD_BITS-1:0] centroid_y;
		logic [CNT_W-1:0]             member_count;
		logic [CNT_W-1:0]             cluster_count;
		logic                         overflow;
		logic                         last;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0] min_points;
		logic [EPS_W-1:0] eps_squared;
		logic [CNT_W-1:0] max_clusters;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LOAD, ST_CINIT, ST_SEED, ST_ROW_A, ST_ROW_B, ST_SCAN, ST_DEC,
		ST_SSUM, ST_ENQ, ST_EXP, ST_EXP_Q, ST_EXP_T, ST_EXP_S,
		ST_OUT_A, ST_OUT_B, ST_OUT_C, ST_OUT_D
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_TAKE, OP_ROW_WR, OP_CL_INIT, OP_SEED_SKIP, OP_SEED_OPEN,
		OP_ROW_RD, OP_SCAN_GO, OP_NOISE, OP_REFUSE, OP_CL_OPEN, OP_SEED_SUM,
		OP_ENQ, OP_EXP_TAKE, OP_EXP_SUM, OP_CL_CLOSE, OP_OUT_INIT, OP_DIV_GO,
		OP_EMIT, OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic last;
		logic seed_end;
		logic seed_vis;
		logic core;
		logic cap_hit;
		logic enq_end;
		logic q_empty;
		logic unvisited;
		logic out_end;
		logic div_done;
	} stat_t;

endpackage
`default_nettype wire

// File: rtl/dpc_div.sv
// Restoring divider, one quotient bit per cycle: signed sum over unsigned count.
// Depends on dpc_pkg.
`default_nettype none
module dpc_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               go,
	input  logic signed [dpc_pkg::SUM_W-1:0]   dividend,
	input  logic [dpc_pkg::CNT_W-1:0]          divisor,
	output logic                               done,
	output logic signed [dpc_pkg::COORD_BITS-1:0] quotient
);
	import dpc_pkg::*;

	logic              act_q, done_q, neg_q;
	logic [STEP_W-1:0] cnt_q;
	logic [CNT_W-1:0]  rem_q, dvs_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !go && act_q && (cnt_q == STEP_W'(SUM_W - 1));
			if (go) begin
				act_q <= 1'b1;
				cnt_q <= '0;
			end else if (act_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(SUM_W - 1))
					act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (act_q) begin
			rem_q <= ge ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q[COORD_BITS-1:0] + COORD_BITS'(1))
	                        : quo_q[COORD_BITS-1:0];

endmodule
`default_nettype wire

// File: rtl/dpc_dpath.sv
// Datapath: point, neighbor-row, queue, label and cluster-sum memories, scan pipeline, dividers.
// Depends on dpc_pkg and dpc_div.
`default_nettype none
module dpc_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  dpc_pkg::point_t   point,
	input  dpc_pkg::cfg_t     cfg,
	input  dpc_pkg::cmd_t     cmd,
	output dpc_pkg::stat_t    stat,
	output dpc_pkg::result_t  result,
	output logic              result_valid
);
	import dpc_pkg::*;

	// memories
	logic [PT_W-1:0]       pt_mem  [MAX_POINTS];
	logic [MAX_POINTS-1:0] mx_mem  [MAX_POINTS];
	logic [IDX_W-1:0]      q_mem   [MAX_POINTS];
	logic [IDX_W-1:0]      lbl_mem [MAX_POINTS];
	logic [2*SUM_W-1:0]    sum_mem [MAX_POINTS];
	logic [CNT_W-1:0]      cnt_mem [MAX_POINTS];

	logic [PT_W-1:0]       pt_rd_q;
	logic [MAX_POINTS-1:0] mx_rd_q;
	logic [IDX_W-1:0]      q_rd_q, lbl_rd_q;
	logic [2*SUM_W-1:0]    sum_rd_q;
	logic [CNT_W-1:0]      cnt_rd_q;

	point_t                cur_q;
	logic [CNT_W-1:0]      loaded_q;

	// scan engine
	logic                  sc_act_q, sc_load_q;
	logic [IDX_W-1:0]      sc_iss_q;
	logic [CNT_W-1:0]      sc_end_q;
	logic                  v_s1, v_s2;
	logic [IDX_W-1:0]      idx_s1, idx_s2;
	logic [SQ_W-1:0]       sqx_s2, sqy_s2;

	logic [MAX_POINTS-1:0] row_q, rowp_q, nbr_q;
	logic [CNT_W-1:0]      ncnt_q;

	// clustering state
	logic [CNT_W-1:0]      i_q, qlen_q, qhead_q, clus_q, ccnt_q, o_q;
	logic [IDX_W-1:0]      pp_q, j_q;
	logic [MAX_POINTS-1:0] vis_q, noise_q, mem_q;
	logic                  ovf_q, unv_q;
	logic signed [SUM_W-1:0] sx_q, sy_q;

	result_t               res_q;
	logic                  rv_q;

	logic                  room, cand, nb_bit, near;
	logic [IDX_W-1:0]      pt_addr, mx_addr, lbl_waddr;
	logic                  lbl_we;
	logic [CNT_W-1:0]      limit;
	logic signed [COORD_BITS-1:0] px, py;
	logic signed [DIFF_W-1:0]     dx, dy;
	logic signed [2*DIFF_W-1:0]   sqx, sqy;
	logic [SQ_W:0]                dsq;
	logic signed [SUM_W-1:0]      px_ext, py_ext;
	logic                  dx_done, dy_done;
	logic signed [COORD_BITS-1:0] qx, qy;

	assign room  = loaded_q < CNT_W'(MAX_POINTS);
	assign limit = (cfg.max_clusters > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
	                                                       : cfg.max_clusters;

	assign px     = pt_rd_q[PT_W-1:COORD_BITS];
	assign py     = pt_rd_q[COORD_BITS-1:0];
	assign px_ext = {{(SUM_W-COORD_BITS){px[COORD_BITS-1]}}, px};
	assign py_ext = {{(SUM_W-COORD_BITS){py[COORD_BITS-1]}}, py};

	// distance terms, stage 1
	assign dx   = {cur_q.x_coord[COORD_BITS-1], cur_q.x_coord} - {px[COORD_BITS-1], px};
	assign dy   = {cur_q.y_coord[COORD_BITS-1], cur_q.y_coord} - {py[COORD_BITS-1], py};
	assign sqx  = dx * dx;
	assign sqy  = dy * dy;
	// stage 2
	assign dsq  = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign near = dsq < (SQ_W+1)'(cfg.eps_squared);

	// neighbor bit of row pp: lower part from its own row, upper from later rows
	assign nb_bit = (idx_s1 <= pp_q) ? rowp_q[idx_s1] : mx_rd_q[pp_q];

	assign cand = nbr_q[j_q] && (!vis_q[j_q] || noise_q[j_q]) && !mem_q[j_q]
	              && (qlen_q < CNT_W'(MAX_POINTS));

	always_comb begin
		pt_addr = sc_iss_q;
		mx_addr = sc_iss_q;
		case (cmd.op)
			OP_CL_OPEN:  pt_addr = i_q[IDX_W-1:0];
			OP_EXP_TAKE: pt_addr = q_rd_q;
			OP_ROW_RD:   mx_addr = pp_q;
			default: ;
		endcase
		lbl_we    = (cmd.op == OP_CL_OPEN) || (cmd.op == OP_EXP_TAKE);
		lbl_waddr = (cmd.op == OP_CL_OPEN) ? i_q[IDX_W-1:0] : q_rd_q;
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (cmd.op == OP_TAKE && room)
			pt_mem[loaded_q[IDX_W-1:0]] <= {point.x_coord, point.y_coord};
		pt_rd_q <= pt_mem[pt_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ROW_WR && room)
			mx_mem[loaded_q[IDX_W-1:0]] <= row_q | (MAX_POINTS'(1) << loaded_q[IDX_W-1:0]);
		mx_rd_q <= mx_mem[mx_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ENQ && cand)
			q_mem[qlen_q[IDX_W-1:0]] <= j_q;
		q_rd_q <= q_mem[qhead_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (lbl_we)
			lbl_mem[lbl_waddr] <= clus_q[IDX_W-1:0];
		lbl_rd_q <= lbl_mem[o_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CL_CLOSE) begin
			sum_mem[clus_q[IDX_W-1:0]] <= {sx_q, sy_q};
			cnt_mem[clus_q[IDX_W-1:0]] <= ccnt_q;
		end
		sum_rd_q <= sum_mem[lbl_rd_q];
		cnt_rd_q <= cnt_mem[lbl_rd_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == OP_TAKE)
			cur_q <= point;
		idx_s1 <= sc_iss_q;
		idx_s2 <= idx_s1;
		sqx_s2 <= sqx[SQ_W-1:0];
		sqy_s2 <= sqy[SQ_W-1:0];
	end

	// control and working state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= '0;
			sc_act_q  <= 1'b0;
			sc_load_q <= 1'b0;
			sc_iss_q  <= '0;
			sc_end_q  <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			row_q     <= '0;
			rowp_q    <= '0;
			nbr_q     <= '0;
			ncnt_q    <= '0;
			i_q       <= '0;
			qlen_q    <= '0;
			qhead_q   <= '0;
			clus_q    <= '0;
			ccnt_q    <= '0;
			o_q       <= '0;
			pp_q      <= '0;
			j_q       <= '0;
			vis_q     <= '0;
			noise_q   <= '0;
			mem_q     <= '0;
			ovf_q     <= 1'b0;
			unv_q     <= 1'b0;
			sx_q      <= '0;
			sy_q      <= '0;
			rv_q      <= 1'b0;
		end else begin
			rv_q <= cmd.op == OP_EMIT;

			// scan issue and pipeline
			v_s1 <= sc_act_q;
			v_s2 <= v_s1 && sc_load_q;
			if (sc_act_q) begin
				sc_iss_q <= sc_iss_q + IDX_W'(1);
				if ({1'b0, sc_iss_q} + CNT_W'(1) == sc_end_q)
					sc_act_q <= 1'b0;
			end
			if (v_s2)
				row_q[idx_s2] <= near;
			if (v_s1 && !sc_load_q) begin
				nbr_q[idx_s1] <= nb_bit;
				ncnt_q        <= ncnt_q + CNT_W'(nb_bit);
			end

			case (cmd.op)
				OP_TAKE: begin
					row_q     <= '0;
					sc_load_q <= 1'b1;
					sc_iss_q  <= '0;
					sc_end_q  <= loaded_q;
					sc_act_q  <= room && (loaded_q != '0);
				end
				OP_ROW_WR: begin
					if (room)
						loaded_q <= loaded_q + CNT_W'(1);
				end
				OP_CL_INIT: begin
					i_q     <= '0;
					clus_q  <= '0;
					ovf_q   <= 1'b0;
					vis_q   <= '0;
					noise_q <= '0;
				end
				OP_SEED_SKIP: i_q <= i_q + CNT_W'(1);
				OP_SEED_OPEN: begin
					vis_q[i_q[IDX_W-1:0]] <= 1'b1;
					pp_q                  <= i_q[IDX_W-1:0];
				end
				OP_SCAN_GO: begin
					rowp_q    <= mx_rd_q;
					nbr_q     <= '0;
					ncnt_q    <= '0;
					sc_act_q  <= 1'b1;
					sc_load_q <= 1'b0;
					sc_iss_q  <= '0;
					sc_end_q  <= loaded_q;
					j_q       <= '0;
				end
				OP_NOISE: begin
					noise_q[i_q[IDX_W-1:0]] <= 1'b1;
					i_q                     <= i_q + CNT_W'(1);
				end
				OP_REFUSE: begin
					noise_q[i_q[IDX_W-1:0]] <= 1'b1;
					ovf_q                   <= 1'b1;
					i_q                     <= i_q + CNT_W'(1);
				end
				OP_CL_OPEN: begin
					mem_q   <= MAX_POINTS'(1) << i_q[IDX_W-1:0];
					qlen_q  <= '0;
					qhead_q <= '0;
				end
				OP_SEED_SUM: begin
					sx_q   <= px_ext;
					sy_q   <= py_ext;
					ccnt_q <= CNT_W'(1);
					j_q    <= '0;
				end
				OP_ENQ: begin
					if (cand) begin
						mem_q[j_q] <= 1'b1;
						qlen_q     <= qlen_q + CNT_W'(1);
					end
					j_q <= j_q + IDX_W'(1);
				end
				OP_EXP_TAKE: begin
					pp_q            <= q_rd_q;
					noise_q[q_rd_q] <= 1'b0;
					unv_q           <= !vis_q[q_rd_q];
					vis_q[q_rd_q]   <= 1'b1;
				end
				OP_EXP_SUM: begin
					sx_q    <= sx_q + px_ext;
					sy_q    <= sy_q + py_ext;
					ccnt_q  <= ccnt_q + CNT_W'(1);
					qhead_q <= qhead_q + CNT_W'(1);
				end
				OP_CL_CLOSE: begin
					clus_q <= clus_q + CNT_W'(1);
					i_q    <= i_q + CNT_W'(1);
				end
				OP_OUT_INIT: o_q <= '0;
				OP_EMIT: o_q <= o_q + CNT_W'(1);
				OP_FINISH: loaded_q <= '0;
				default: ;
			endcase
		end
	end

	// centroid dividers
	dpc_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.op == OP_DIV_GO),
		.dividend (sum_rd_q[2*SUM_W-1:SUM_W]),
		.divisor  (cnt_rd_q),
		.done     (dx_done),
		.quotient (qx)
	);

	dpc_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.op == OP_DIV_GO),
		.dividend (sum_rd_q[SUM_W-1:0]),
		.divisor  (cnt_rd_q),
		.done     (dy_done),
		.quotient (qy)
	);

	// result word
	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			res_q.point_index   <= o_q[IDX_W-1:0];
			res_q.cluster_count <= clus_q;
			res_q.overflow      <= ovf_q;
			res_q.last          <= (o_q + CNT_W'(1)) == loaded_q;
			if (noise_q[o_q[IDX_W-1:0]]) begin
				res_q.is_noise      <= 1'b1;
				res_q.cluster_label <= '0;
				res_q.centroid_x    <= '0;
				res_q.centroid_y    <= '0;
				res_q.member_count  <= '0;
			end else begin
				res_q.is_noise      <= 1'b0;
				res_q.cluster_label <= lbl_rd_q;
				res_q.centroid_x    <= qx;
				res_q.centroid_y    <= qy;
				res_q.member_count  <= cnt_rd_q;
			end
		end
	end

	always_comb begin
		stat.scan_done = !sc_act_q && !v_s1 && !v_s2;
		stat.last      = cur_q.last_point;
		stat.seed_end  = i_q == loaded_q;
		stat.seed_vis  = vis_q[i_q[IDX_W-1:0]];
		stat.core      = ncnt_q >= cfg.min_points;
		stat.cap_hit   = clus_q >= limit;
		stat.enq_end   = ({1'b0, j_q} + CNT_W'(1)) == loaded_q;
		stat.q_empty   = qhead_q == qlen_q;
		stat.unvisited = unv_q;
		stat.out_end   = o_q == loaded_q;
		stat.div_done  = dx_done && dy_done;
	end

	assign result       = res_q;
	assign result_valid = rv_q;

endmodule
`default_nettype wire

// File: rtl/dpc_ctrl.sv
// Sequencer for loading, cluster growth and result output.
// Depends on dpc_pkg.
`default_nettype none
module dpc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  dpc_pkg::stat_t  stat,
	output logic            busy,
	output dpc_pkg::cmd_t   cmd
);
	import dpc_pkg::*;

	state_t state_q, state_d;
	logic   exp_q, exp_d;   // scan belongs to an expansion, not a seed

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			exp_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			exp_q   <= exp_d;
		end
	end

	always_comb begin
		state_d = state_q;
		exp_d   = exp_q;
		cmd.op  = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.op  = OP_TAKE;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (stat.scan_done) begin
					cmd.op  = OP_ROW_WR;
					state_d = stat.last ? ST_CINIT : ST_IDLE;
				end
			end
			ST_CINIT: begin
				cmd.op  = OP_CL_INIT;
				state_d = ST_SEED;
			end
			ST_SEED: begin
				if (stat.seed_end) begin
					cmd.op  = OP_OUT_INIT;
					state_d = ST_OUT_A;
				end else if (stat.seed_vis) begin
					cmd.op = OP_SEED_SKIP;
				end else begin
					cmd.op  = OP_SEED_OPEN;
					exp_d   = 1'b0;
					state_d = ST_ROW_A;
				end
			end
			ST_ROW_A: begin
				cmd.op  = OP_ROW_RD;
				state_d = ST_ROW_B;
			end
			ST_ROW_B: begin
				cmd.op  = OP_SCAN_GO;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_done)
					state_d = ST_DEC;
			end
			ST_DEC: begin
				if (exp_q) begin
					state_d = stat.core ? ST_ENQ : ST_EXP;
				end else if (!stat.core) begin
					cmd.op  = OP_NOISE;
					state_d = ST_SEED;
				end else if (stat.cap_hit) begin
					cmd.op  = OP_REFUSE;
					state_d = ST_SEED;
				end else begin
					cmd.op  = OP_CL_OPEN;
					state_d = ST_SSUM;
				end
			end
			ST_SSUM: begin
				cmd.op  = OP_SEED_SUM;
				state_d = ST_ENQ;
			end
			ST_ENQ: begin
				cmd.op = OP_ENQ;
				if (stat.enq_end)
					state_d = ST_EXP;
			end
			ST_EXP: begin
				if (stat.q_empty) begin
					cmd.op  = OP_CL_CLOSE;
					state_d = ST_SEED;
				end else begin
					state_d = ST_EXP_Q;
				end
			end
			ST_EXP_Q: state_d = ST_EXP_T;
			ST_EXP_T: begin
				cmd.op  = OP_EXP_TAKE;
				state_d = ST_EXP_S;
			end
			ST_EXP_S: begin
				cmd.op = OP_EXP_SUM;
				if (stat.unvisited) begin
					exp_d   = 1'b1;
					state_d = ST_ROW_A;
				end else begin
					state_d = ST_EXP;
				end
			end
			ST_OUT_A: begin
				if (stat.out_end) begin
					cmd.op  = OP_FINISH;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_OUT_B;
				end
			end
			ST_OUT_B: state_d = ST_OUT_C;
			ST_OUT_C: begin
				cmd.op  = OP_DIV_GO;
				state_d = ST_OUT_D;
			end
			ST_OUT_D: begin
				if (stat.div_done) begin
					cmd.op  = OP_EMIT;
					state_d = ST_OUT_A;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = state_q != ST_IDLE;

endmodule
`default_nettype wire

// File: rtl/dbscan_point_clustering_unit.sv
// Top level of the point clustering unit: configuration registers, sequencer, datapath.
// Depends on dpc_pkg, dpc_ctrl, dpc_dpath (with dpc_div) and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// Usage:
//  - Points go in one word at a time: a word is taken on a clock edge with start high and
//    busy low. Each point is stored and compared with every point already held; busy
//    stays high until the compares are done (one compare per cycle, two-stage square/compare).
//  - Up to 64 points per set; later points are dropped, but a dropped point carrying
//    last_point still starts clustering.
//  - The word with last_point set starts clustering in load order. Every visited point
//    costs one neighbor-row scan (one matrix memory read per cycle), every core point that
//    opens or joins a cluster an extra queue pass, and each queued point a take-and-sum step.
//  - Then one result word per stored point, in load order, each waiting on its divide:
//    the centroid divide runs one quotient bit per cycle. result_valid is high for one
//    cycle per word; the receiver cannot stall and must take it. busy drops after the
//    final word (marked by last) and the set starts empty.
//  - Configuration writes (cfg_valid, cfg_index, cfg_data) are always ready and should be
//    made while busy is low; they apply to the next loads and clustering run.
//  - Reset clears the point count, the sequencer and the configuration to its defaults.
//    Memories hold no reset value and need no clearing pass.
module dbscan_point_clustering_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  dpc_pkg::point_t               point,
	output dpc_pkg::result_t              result,
	output logic                          result_valid,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dpc_pkg::EPS_W-1:0]     cfg_data
);
	import dpc_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	// register file; writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_points   <= CNT_W'(4);
			cfg_q.eps_squared  <= EPS_W'(10000);
			cfg_q.max_clusters <= CNT_W'(64);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MIN_POINTS:   cfg_q.min_points   <= cfg_data[CNT_W-1:0];
				REG_EPS_SQUARED:  cfg_q.eps_squared  <= cfg_data;
				REG_MAX_CLUSTERS: cfg_q.max_clusters <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: owns the state machine, accepts start while idle
	dpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath: memories, scan pipeline, marks, sums and result register
	dpc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.point        (point),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

	// a result word only appears during a run
	`ASSERT_IMP(a_result_in_run, result_valid, busy)
	// result words are never back to back (each waits on a divide)
	`ASSERT_NXT(a_result_spaced, result_valid, !result_valid)
	// an accepted word always starts work
	`ASSERT_NXT(a_start_takes, start && !busy, busy)

endmodule
`default_nettype wire

// File: tb/tb_dbscan_point_clustering_unit.sv
// Testbench for dbscan_point_clustering_unit: loads point sets, clusters them and checks
// every result word against a predictor kept in a small scoreboard class.
// Depends on dpc_pkg and the RTL of the unit only.
`timescale 1ns / 1ps
module tb_dbscan_point_clustering_unit;
	import dpc_pkg::*;

	// Predictor of the unit plus the queue of result words still owed by the DUT.
	class cluster_scoreboard;
		logic [CNT_W-1:0] min_pts;
		logic [EPS_W-1:0] eps_sq;
		logic [CNT_W-1:0] max_cl;
		longint           px[MAX_POINTS];
		longint           py[MAX_POINTS];
		bit [MAX_POINTS-1:0] nbr[MAX_POINTS];
		int               n_loaded;
		bit               visited[MAX_POINTS];
		bit               noise[MAX_POINTS];
		bit               member[MAX_POINTS];
		int               walk_q[MAX_POINTS];
		int               walk_len;
		result_t          owed_q[$];
		int               errors;

		function new();
			min_pts  = CNT_W'(4);
			eps_sq   = EPS_W'(10000);
			max_cl   = CNT_W'(64);
			n_loaded = 0;
			errors   = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [EPS_W-1:0] val);
			case (idx)
				REG_MIN_POINTS:   min_pts = val[CNT_W-1:0];
				REG_EPS_SQUARED:  eps_sq  = val;
				REG_MAX_CLUSTERS: max_cl  = val[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [MAX_POINTS-1:0] live_mask();
			if (n_loaded >= MAX_POINTS)
				return '1;
			return (64'd1 << n_loaded) - 64'd1;
		endfunction

		function bit core_pt(int p);
			return $countones(nbr[p] & live_mask()) >= min_pts;
		endfunction

		function void queue_nbrs(int p);
			for (int j = 0; j < n_loaded; j++) begin
				if (nbr[p][j] && (!visited[j] || noise[j]) && !member[j] &&
						walk_len < MAX_POINTS) begin
					member[j] = 1;
					walk_q[walk_len++] = j;
				end
			end
		endfunction

		// Called once per accepted point word.
		function void note_point(point_t w);
			longint dx, dy;
			longint unsigned d;
			int n;
			n = n_loaded;
			if (n < MAX_POINTS) begin
				px[n] = longint'($signed(w.x_coord));
				py[n] = longint'($signed(w.y_coord));
				nbr[n][n] = 1;
				for (int i = 0; i < n; i++) begin
					dx = px[n] - px[i];
					dy = py[n] - py[i];
					d  = dx * dx + dy * dy;
					nbr[n][i] = (d < longint'(eps_sq));
					nbr[i][n] = nbr[n][i];
				end
				n_loaded++;
			end
			if (w.last_point)
				cluster_set();
		endfunction

		// Clustering in load order, then one owed word per stored point.
		function void cluster_set();
			int      lab[MAX_POINTS];
			longint  sx[MAX_POINTS];
			longint  sy[MAX_POINTS];
			int      cnt[MAX_POINTS];
			int      made, lim, c, p;
			bit      ovf;
			result_t r;
			lim  = (max_cl < 64) ? int'(max_cl) : 64;
			made = 0;
			ovf  = 0;
			for (int i = 0; i < MAX_POINTS; i++) begin
				visited[i] = 0;
				noise[i]   = 0;
			end
			for (int i = 0; i < n_loaded; i++) begin
				if (visited[i])
					continue;
				visited[i] = 1;
				if (!core_pt(i) || made >= lim) begin
					noise[i] = 1;
					if (core_pt(i))
						ovf = 1;
					continue;
				end
				c = made;
				lab[i] = c;
				sx[c]  = px[i];
				sy[c]  = py[i];
				cnt[c] = 1;
				for (int j = 0; j < MAX_POINTS; j++)
					member[j] = 0;
				member[i] = 1;
				walk_len = 0;
				queue_nbrs(i);
				for (int k = 0; k < walk_len; k++) begin
					p = walk_q[k];
					lab[p]   = c;
					noise[p] = 0;
					sx[c] += px[p];
					sy[c] += py[p];
					cnt[c]++;
					if (!visited[p]) begin
						visited[p] = 1;
						if (core_pt(p))
							queue_nbrs(p);
					end
				end
				made++;
			end
			for (int i = 0; i < n_loaded; i++) begin
				r = '0;
				r.point_index = IDX_W'(i);
				if (noise[i]) begin
					r.is_noise = 1'b1;
				end else begin
					c = lab[i] % 64;
					r.cluster_label = IDX_W'(c);
					r.centroid_x    = COORD_BITS'(sx[c] / cnt[c]);
					r.centroid_y    = COORD_BITS'(sy[c] / cnt[c]);
					r.member_count  = CNT_W'(cnt[c]);
				end
				r.cluster_count = CNT_W'(made);
				r.overflow      = ovf;
				r.last          = (i == n_loaded - 1);
				owed_q.push_back(r);
			end
			n_loaded = 0;
		endfunction

		function void cmp(string fld, longint e, longint a);
			if (e != a) begin
				$error("%s mismatch: expected %0d, got %0d", fld, e, a);
				errors++;
			end
		endfunction

		function void check_word(result_t a);
			result_t e;
			if (owed_q.size() == 0) begin
				$error("unexpected result word, index %0d", a.point_index);
				errors++;
				return;
			end
			e = owed_q.pop_front();
			cmp("point_index", e.point_index, a.point_index);
			cmp("cluster_label", e.cluster_label, a.cluster_label);
			cmp("is_noise", e.is_noise, a.is_noise);
			cmp("centroid_x", $signed(e.centroid_x), $signed(a.centroid_x));
			cmp("centroid_y", $signed(e.centroid_y), $signed(a.centroid_y));
			cmp("member_count", e.member_count, a.member_count);
			cmp("cluster_count", e.cluster_count, a.cluster_count);
			cmp("overflow", e.overflow, a.overflow);
			cmp("last", e.last, a.last);
		endfunction
	endclass

	localparam int WATCHDOG = 200000;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 start = 0;
	logic                 busy;
	point_t               point = '0;
	result_t              result;
	logic                 result_valid;
	logic                 cfg_valid = 0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MIN_POINTS;
	logic [EPS_W-1:0]     cfg_data = '0;

	cluster_scoreboard sb = new();
	int  items_sent = 0;
	int  quiet = 0;
	bit  timed_out = 0;
	bit  no_gaps = 0;    // set per point set: back-to-back words
	int  cx[8];
	int  cy[8];

	always #5 clk = ~clk;

	dbscan_point_clustering_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.point        (point),
		.result       (result),
		.result_valid (result_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Result words cannot be held off: check each one on the edge that takes it.
	always @(posedge clk)
		if (arst_n && result_valid)
			sb.check_word(result);

	// Watchdog: count cycles with no handshake of any kind.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("FAIL dbscan_point_clustering_unit");
			$finish;
		end
	end

	// One point word; waits out a random gap, then holds start until busy is low.
	task automatic send_point(int x, int y, bit fin);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
		point.x_coord    = x[15:0];
		point.y_coord    = y[15:0];
		point.last_point = fin;
		start = 1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		sb.note_point(point);
		items_sent++;
		@(negedge clk);
		if (fin)
			start = 0;
	endtask

	// Block is idle only once every owed word is out and busy has dropped.
	task automatic wait_idle();
		start = 0;
		while (sb.owed_q.size() != 0 || busy)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EPS_W-1:0] val);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data  = val;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_config(int mp, longint unsigned eps, int mc);
		wait_idle();
		write_reg(REG_MIN_POINTS, EPS_W'(mp));
		write_reg(REG_EPS_SQUARED, EPS_W'(eps));
		write_reg(REG_MAX_CLUSTERS, EPS_W'(mc));
	endtask

	function automatic int clamp16(int v);
		return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
	endfunction

	// A set of n points: either blobs around a few centers scaled to the current
	// radius (with about one point in ten stray), or coordinates spread over the whole range.
	task automatic send_set(int n);
		int  ncent, r, k, x, y;
		bit  uniform;
		no_gaps = ($urandom_range(0, 3) == 0);
		uniform = ($urandom_range(0, 4) == 0);
		ncent   = $urandom_range(1, 5);
		r = $rtoi($sqrt(real'(sb.eps_sq))) + 1;
		if (r > 20000)
			r = 20000;
		for (int i = 0; i < ncent; i++) begin
			cx[i] = $signed(16'($urandom));
			cy[i] = $signed(16'($urandom));
		end
		for (int i = 0; i < n; i++) begin
			if (uniform || $urandom_range(0, 9) == 0) begin
				x = $signed(16'($urandom));
				y = $signed(16'($urandom));
			end else begin
				k = $urandom_range(0, ncent - 1);
				x = clamp16(cx[k] + $urandom_range(0, 2 * r) - r);
				y = clamp16(cy[k] + $urandom_range(0, 2 * r) - r);
			end
			send_point(x, y, i == n - 1);
		end
	endtask

	initial begin
		int n;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed, reset configuration: full-scale corners, a single point,
		// a tight core group that absorbs an earlier noise point.
		send_point(-32768, -32768, 0);
		send_point(32767, 32767, 0);
		send_point(-32768, 32767, 0);
		send_point(0, 0, 1);
		send_point(5, 5, 1);
		send_point(150, 0, 0);        // noise at its visit, border later
		send_point(0, 0, 0);
		send_point(10, 0, 0);
		send_point(0, 10, 0);
		send_point(-10, -10, 0);
		send_point(80, 0, 1);

		// Every point core; zero radius still keeps each point its own neighbor.
		set_config(1, 0, 64);
		send_point(-1, -1, 0);
		send_point(-1, -1, 0);
		send_point(7, -3, 1);

		// Cap of zero and of one, widest radius, out-of-range register values.
		set_config(2, 64'h1_FFFF_FFFF, 0);
		send_point(32767, -32768, 0);
		send_point(-32768, 32767, 1);
		set_config(0, 64'h1_FFFF_FFFF, 1);
		send_point(1, 2, 0);
		send_point(-3, 4, 1);
		set_config(127, 1000, 127);
		send_point(0, 0, 0);
		send_point(1, 1, 1);

		// Hold off the sender until the block has drained.
		wait_idle();

		while (items_sent < 450) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 5))
					0: set_config(1, 64'($urandom_range(0, 400)), $urandom_range(1, 64));
					1: set_config(64, 64'h1_FFFF_FFFF, 64);
					2: set_config($urandom_range(1, 6), 64'($urandom_range(1, 50000)),
							$urandom_range(1, 3));
					3: set_config($urandom_range(0, 127), {$urandom_range(0, 1), $urandom()},
							$urandom_range(0, 127));
					default: set_config($urandom_range(2, 5),
							64'($urandom_range(100, 4000000)), $urandom_range(1, 64));
				endcase
			end
			case ($urandom_range(0, 19))
				0:       n = $urandom_range(64, 67);   // store full, any beyond 64 dropped
				1, 2:    n = $urandom_range(20, 40);
				default: n = $urandom_range(1, 12);
			endcase
			send_set(n);
		end

		wait_idle();
		repeat (100) @(negedge clk);
		if (sb.errors == 0 && sb.owed_q.size() == 0)
			$display("PASS dbscan_point_clustering_unit");
		else
			$display("FAIL dbscan_point_clustering_unit");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/dpc_pkg.sv
rtl/dpc_div.sv
rtl/dpc_dpath.sv
rtl/dpc_ctrl.sv
rtl/dbscan_point_clustering_unit.sv
tb/tb_dbscan_point_clustering_unit.sv
